// File: src/hav_pkg.sv
// shared widths, latencies and cordic tables for the haversine distance pipeline
package hav_pkg;

   // request and response field widths
   localparam int LAT_W    = 24;
   localparam int LON_W    = 25;
   localparam int DIST_W   = 26;
   localparam int RADIUS_W = 16;

   // angle conversion: sign-extended degrees in, binary angle out
   localparam int ANG_W           = 26;
   localparam int BAM_W           = 32;
   localparam int LAT_FRAC_SHIFT  = 16;
   localparam int HALF_FRAC_SHIFT = 15;

   // cordic datapath
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W     = 34;
   localparam int CZ_W         = BAM_W + 1;
   localparam int TRIG_W       = 32;
   localparam int Q_FRAC       = 30;
   localparam int ATAN_W       = 30;

   localparam logic [CORDIC_W-1:0] CORDIC_GAIN_INV = CORDIC_W'(652032874);

   // arctangent of 2^-i as a binary angle (2^32 per turn)
   localparam logic [ATAN_W-1:0] ATAN_BAM [CORDIC_STEPS] = '{
      ATAN_W'(536870912), ATAN_W'(316933406), ATAN_W'(167458907), ATAN_W'(85004756),
      ATAN_W'(42667331),  ATAN_W'(21354465),  ATAN_W'(10679838),  ATAN_W'(5340245),
      ATAN_W'(2670163),   ATAN_W'(1335087),   ATAN_W'(667544),    ATAN_W'(333772),
      ATAN_W'(166886),    ATAN_W'(83443),     ATAN_W'(41722),     ATAN_W'(20861),
      ATAN_W'(10430),     ATAN_W'(5215),      ATAN_W'(2608),      ATAN_W'(1304),
      ATAN_W'(652),       ATAN_W'(326),       ATAN_W'(163),       ATAN_W'(81)
   };

   // square root: one result bit per stage
   localparam int SQ_STEPS = 31;
   localparam int SQ_W     = 2 * SQ_STEPS;

   // stage counts of the sub-blocks
   localparam int BAM_LAT = 6;
   localparam int ROT_LAT = CORDIC_STEPS + 2;
   localparam int SQ_LAT  = SQ_STEPS + 1;
   localparam int VEC_LAT = CORDIC_STEPS + 1;

endpackage

// File: src/hav_bam.sv
// degrees (16 fractional bits) times 2^shift to a rounded binary angle, pipelined
module hav_bam #(
   parameter int FRAC_SHIFT = hav_pkg::LAT_FRAC_SHIFT
) (
   input  logic                             clock,
   input  logic signed [hav_pkg::ANG_W-1:0] angle_in,
   output logic        [hav_pkg::BAM_W-1:0] bam_out
);
   import hav_pkg::*;

   localparam int HW     = BAM_W - FRAC_SHIFT;
   localparam int REM_W  = 10;
   localparam int YW     = FRAC_SHIFT + REM_W - 1;
   localparam int QW     = FRAC_SHIFT + 1;
   localparam int VP_W   = 34;
   localparam int H_W    = 26;
   localparam int M1_W   = 32;
   localparam int P1_W   = VP_W + M1_W;
   localparam int M2_W   = 25;
   localparam int P2_W   = YW + M2_W;
   localparam int DEG_TURN = 360;
   localparam int HALF_DEG = 180;
   localparam logic [VP_W-1:0] ANGLE_OFFSET = VP_W'(64'd12079595520);
   localparam logic [M1_W-1:0] RECIP_HI = M1_W'(64'd3054198966);
   localparam int RECIP_HI_SHIFT = 40;
   localparam logic [M2_W-1:0] RECIP_LO = M2_W'(23860929);
   localparam int RECIP_LO_SHIFT = 33;

   logic [VP_W-1:0]  vp_in;
   logic [VP_W-1:0]  vp_ff;
   logic [P1_W-1:0]  p1_ff;
   logic [H_W-1:0]   h0_in;
   logic [REM_W-1:0] r0_in;
   logic [H_W-1:0]   h0_ff;
   logic [REM_W-1:0] r0_ff;
   logic             wrap_hi;
   logic [HW-1:0]    h1_in;
   logic [REM_W-1:0] r1;
   logic [YW-1:0]    y_in;
   logic [HW-1:0]    h1_ff;
   logic [YW-1:0]    y_ff;
   logic [P2_W-1:0]  p2_ff;
   logic [HW-1:0]    h2_ff;
   logic [YW-1:0]    y2_ff;
   logic [QW-1:0]    q0_in;
   logic [REM_W-1:0] rem_in;
   logic [QW-1:0]    q0_ff;
   logic [REM_W-1:0] rem_ff;
   logic [HW-1:0]    h3_ff;
   logic [BAM_W-1:0] bam_ff;

   // offset to a positive value; whole turns added vanish modulo 2^32
   assign vp_in = VP_W'(angle_in) + ANGLE_OFFSET;

   // stage 1: reciprocal multiply for the coarse quotient by 360
   always_ff @(posedge clock) begin
      vp_ff <= vp_in;
      p1_ff <= P1_W'(vp_in) * P1_W'(RECIP_HI);
   end

   // stage 2: coarse quotient and its remainder
   assign h0_in = p1_ff[P1_W-1:RECIP_HI_SHIFT];
   assign r0_in = REM_W'(vp_ff - VP_W'(h0_in) * VP_W'(DEG_TURN));

   always_ff @(posedge clock) begin
      h0_ff <= h0_in;
      r0_ff <= r0_in;
   end

   // stage 3: correct the quotient, scale the remainder for rounding
   assign wrap_hi = r0_ff >= REM_W'(DEG_TURN);
   assign h1_in   = h0_ff[HW-1:0] + HW'(wrap_hi);
   assign r1      = wrap_hi ? r0_ff - REM_W'(DEG_TURN) : r0_ff;
   assign y_in    = (YW'(r1) << FRAC_SHIFT) + YW'(HALF_DEG);

   always_ff @(posedge clock) begin
      h1_ff <= h1_in;
      y_ff  <= y_in;
   end

   // stage 4: reciprocal multiply of the scaled remainder
   always_ff @(posedge clock) begin
      p2_ff <= P2_W'(y_ff) * P2_W'(RECIP_LO);
      h2_ff <= h1_ff;
      y2_ff <= y_ff;
   end

   // stage 5: fine quotient and its remainder
   assign q0_in  = p2_ff[P2_W-1:RECIP_LO_SHIFT];
   assign rem_in = REM_W'(y2_ff - YW'(q0_in) * YW'(DEG_TURN));

   always_ff @(posedge clock) begin
      q0_ff  <= q0_in;
      rem_ff <= rem_in;
      h3_ff  <= h2_ff;
   end

   // stage 6: correct and assemble the binary angle
   always_ff @(posedge clock) begin
      bam_ff <= {h3_ff, {FRAC_SHIFT{1'b0}}}
              + BAM_W'(q0_ff + QW'(rem_ff >= REM_W'(DEG_TURN)));
   end

   assign bam_out = bam_ff;

endmodule

// File: src/hav_rot.sv
// pipelined rotation cordic: cosine and sine (q30) of a binary angle
module hav_rot (
   input  logic                              clock,
   input  logic        [hav_pkg::BAM_W-1:0]  angle,
   output logic signed [hav_pkg::TRIG_W-1:0] cos_out,
   output logic signed [hav_pkg::TRIG_W-1:0] sin_out
);
   import hav_pkg::*;

   localparam logic [BAM_W-1:0] QUARTER = BAM_W'(1) << (BAM_W - 2);
   localparam logic [BAM_W-1:0] HALF    = BAM_W'(1) << (BAM_W - 1);

   logic [BAM_W-1:0]           quad_sum;
   logic                       flip_in;
   logic [BAM_W-1:0]           turned;
   logic signed [CORDIC_W-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CZ_W-1:0]     z_ff [CORDIC_STEPS+1];
   logic                       flip_ff [CORDIC_STEPS+1];
   logic signed [TRIG_W-1:0]   cos_ff;
   logic signed [TRIG_W-1:0]   sin_ff;

   // fold the left half-plane onto the right by a half turn
   assign quad_sum = angle + QUARTER;
   assign flip_in  = quad_sum[BAM_W-1];
   assign turned   = flip_in ? angle ^ HALF : angle;

   always_ff @(posedge clock) begin
      x_ff[0]    <= CORDIC_GAIN_INV;
      y_ff[0]    <= '0;
      z_ff[0]    <= CZ_W'($signed(turned));
      flip_ff[0] <= flip_in;
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CORDIC_W-1:0] x_in;
      logic signed [CORDIC_W-1:0] y_in;
      logic signed [CZ_W-1:0]     z_in;

      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - CZ_W'(ATAN_BAM[i]);
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + CZ_W'(ATAN_BAM[i]);
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= z_in;
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   // undo the half-turn fold
   always_ff @(posedge clock) begin
      cos_ff <= TRIG_W'(flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS]);
      sin_ff <= TRIG_W'(flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS]);
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// File: src/hav_isqrt.sv
// pipelined integer square root, one result bit per stage
module hav_isqrt (
   input  logic                            clock,
   input  logic [hav_pkg::SQ_W-1:0]        radicand,
   output logic [hav_pkg::SQ_STEPS-1:0]    root
);
   import hav_pkg::*;

   logic [SQ_W-1:0] rem_ff  [SQ_STEPS+1];
   logic [SQ_W-1:0] root_ff [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      rem_ff[0]  <= radicand;
      root_ff[0] <= '0;
   end

   // trial subtract at bit weight 4^(SQ_STEPS-1-k)
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_digit
      localparam logic [SQ_W-1:0] WEIGHT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
      logic [SQ_W-1:0] trial;
      logic [SQ_W-1:0] rem_in;
      logic [SQ_W-1:0] root_in;

      always_comb begin
         trial = root_ff[k] + WEIGHT;
         if (rem_ff[k] >= trial) begin
            rem_in  = rem_ff[k] - trial;
            root_in = (root_ff[k] >> 1) + WEIGHT;
         end else begin
            rem_in  = rem_ff[k];
            root_in = root_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
      end
   end

   assign root = root_ff[SQ_STEPS][SQ_STEPS-1:0];

endmodule

// File: src/hav_vec.sv
// pipelined vectoring cordic: atan2(y, x) as a binary angle
module hav_vec (
   input  logic                             clock,
   input  logic        [hav_pkg::SQ_STEPS-1:0] x_start,
   input  logic        [hav_pkg::SQ_STEPS-1:0] y_start,
   output logic signed [hav_pkg::CZ_W-1:0]     angle_out
);
   import hav_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CZ_W-1:0]     z_ff [CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      x_ff[0] <= CORDIC_W'(x_start);
      y_ff[0] <= CORDIC_W'(y_start);
      z_ff[0] <= '0;
   end

   // drive y toward zero, accumulating the angle
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CORDIC_W-1:0] x_in;
      logic signed [CORDIC_W-1:0] y_in;
      logic signed [CZ_W-1:0]     z_in;

      always_comb begin
         if (y_ff[i] > 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + CZ_W'(ATAN_BAM[i]);
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - CZ_W'(ATAN_BAM[i]);
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1] <= x_in;
         y_ff[i+1] <= y_in;
         z_ff[i+1] <= z_in;
      end
   end

   assign angle_out = z_ff[CORDIC_STEPS];

endmodule

// File: src/haversine_distance.sv
// top level: haversine great-circle distance pipeline with radius register
//
// A request is taken on any clock edge with start high (busy is always low):
// two points, latitude and longitude in signed degrees with 16 fractional
// bits. One result per request appears on rsp_arc_distance for exactly one
// cycle, flagged by rsp_valid, in radius units with 8 fractional bits,
// rounded and saturated at its maximum.
// From the accepting edge a request passes the input register, angle
// conversion, sine/cosine cordic, products and clamp, square root (one
// result bit per stage), atan2 cordic and radius scaling, in that order.
// A new request may enter on every cycle; the pipeline never stalls since
// the receiver always takes results.
// The radius register (reset 6371) lives at byte address 0 of the APB port;
// write it only while no request is in flight.
// Reset clears the valid pipeline and sets the radius register to 6371;
// in-flight requests are dropped.
module haversine_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [hav_pkg::LAT_W-1:0]    req_first_latitude,
   input  logic signed [hav_pkg::LON_W-1:0]    req_first_longitude,
   input  logic signed [hav_pkg::LAT_W-1:0]    req_second_latitude,
   input  logic signed [hav_pkg::LON_W-1:0]    req_second_longitude,
   output logic                                rsp_valid,
   output logic        [hav_pkg::DIST_W-1:0]   rsp_arc_distance,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic        [2:0]                   paddr,
   input  logic        [31:0]                  pwdata,
   output logic        [31:0]                  prdata,
   output logic                                pready
);
   import hav_pkg::*;

   localparam logic RADIUS_IDX = 1'b0;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6371);
   localparam int TOTAL_LAT = 1 + BAM_LAT + ROT_LAT + 3 + SQ_LAT + VEC_LAT + 3;
   localparam int PROD_W  = 2 * TRIG_W;
   localparam int ASUM_W  = TRIG_W + 2;
   localparam int P_W     = RADIUS_W + BAM_W;
   localparam int SPLIT   = 24;
   localparam int PI_W    = 31;
   localparam int T_W     = (P_W - SPLIT) + PI_W;
   localparam int ACC_W   = T_W + 1;
   localparam int OUT_SHIFT = 27;
   localparam int D_W     = ACC_W - OUT_SHIFT;
   localparam logic [PI_W-1:0]  PI_Q29   = PI_W'(1686629713);
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (OUT_SHIFT - 1);
   localparam logic [D_W-1:0]   DIST_MAX = D_W'(52707179);
   localparam logic [Q_FRAC:0]  Q_ONE    = (Q_FRAC + 1)'(1) << Q_FRAC;

   logic [RADIUS_W-1:0]         radius_ff;
   logic [TOTAL_LAT-1:0]        vld_ff;
   logic signed [ANG_W-1:0]     lat1_ff;
   logic signed [ANG_W-1:0]     lat2_ff;
   logic signed [ANG_W-1:0]     dlat_ff;
   logic signed [ANG_W-1:0]     dlon_ff;
   logic [BAM_W-1:0]            bam_lat1;
   logic [BAM_W-1:0]            bam_lat2;
   logic [BAM_W-1:0]            bam_dlat;
   logic [BAM_W-1:0]            bam_dlon;
   logic signed [TRIG_W-1:0]    cos_lat1;
   logic signed [TRIG_W-1:0]    cos_lat2;
   logic signed [TRIG_W-1:0]    sin_dlat;
   logic signed [TRIG_W-1:0]    sin_dlon;
   logic signed [PROD_W-1:0]    pcc_ff;
   logic signed [PROD_W-1:0]    phl_ff;
   logic signed [PROD_W-1:0]    pho_ff;
   logic signed [TRIG_W-1:0]    cc;
   logic signed [TRIG_W-1:0]    ho2;
   logic signed [PROD_W-1:0]    p2_ff;
   logic signed [TRIG_W-1:0]    hl2_ff;
   logic signed [ASUM_W-1:0]    a_sum;
   logic [Q_FRAC:0]             a_in;
   logic [Q_FRAC:0]             a_ff;
   logic [SQ_STEPS-1:0]         root_a;
   logic [SQ_STEPS-1:0]         root_ca;
   logic signed [CZ_W-1:0]      theta;
   logic [BAM_W-1:0]            theta_pos;
   logic [P_W-1:0]              p_ff;
   logic [T_W-1:0]              t1_ff;
   logic [T_W-1:0]              t2_ff;
   logic [ACC_W-1:0]            acc;
   logic [D_W-1:0]              dist_raw;
   logic [DIST_W-1:0]           dist_in;
   logic [DIST_W-1:0]           dist_ff;
   logic                        cfg_wr;

   // config port: radius register
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & (paddr[2] == RADIUS_IDX);
   assign prdata = (paddr[2] == RADIUS_IDX) ? 32'(radius_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (cfg_wr) begin
         radius_ff <= pwdata[RADIUS_W-1:0];
      end
   end

   // request handshake and valid pipeline
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], start};
      end
   end

   // input register with the coordinate differences
   always_ff @(posedge clock) begin
      lat1_ff <= ANG_W'(req_first_latitude);
      lat2_ff <= ANG_W'(req_second_latitude);
      dlat_ff <= ANG_W'(req_second_latitude) - ANG_W'(req_first_latitude);
      dlon_ff <= ANG_W'(req_second_longitude) - ANG_W'(req_first_longitude);
   end

   // angle conversion: full angles for latitudes, half angles for differences
   hav_bam #(.FRAC_SHIFT(LAT_FRAC_SHIFT)) u_bam_lat1 (
      .clock(clock), .angle_in(lat1_ff), .bam_out(bam_lat1));
   hav_bam #(.FRAC_SHIFT(LAT_FRAC_SHIFT)) u_bam_lat2 (
      .clock(clock), .angle_in(lat2_ff), .bam_out(bam_lat2));
   hav_bam #(.FRAC_SHIFT(HALF_FRAC_SHIFT)) u_bam_dlat (
      .clock(clock), .angle_in(dlat_ff), .bam_out(bam_dlat));
   hav_bam #(.FRAC_SHIFT(HALF_FRAC_SHIFT)) u_bam_dlon (
      .clock(clock), .angle_in(dlon_ff), .bam_out(bam_dlon));

   // sine and cosine
   hav_rot u_rot_lat1 (
      .clock(clock), .angle(bam_lat1), .cos_out(cos_lat1), .sin_out());
   hav_rot u_rot_lat2 (
      .clock(clock), .angle(bam_lat2), .cos_out(cos_lat2), .sin_out());
   hav_rot u_rot_dlat (
      .clock(clock), .angle(bam_dlat), .cos_out(), .sin_out(sin_dlat));
   hav_rot u_rot_dlon (
      .clock(clock), .angle(bam_dlon), .cos_out(), .sin_out(sin_dlon));

   // products: cos*cos and the two squared half-angle sines
   always_ff @(posedge clock) begin
      pcc_ff <= PROD_W'(cos_lat1) * PROD_W'(cos_lat2);
      phl_ff <= PROD_W'(sin_dlat) * PROD_W'(sin_dlat);
      pho_ff <= PROD_W'(sin_dlon) * PROD_W'(sin_dlon);
   end

   assign cc  = TRIG_W'(pcc_ff >>> Q_FRAC);
   assign ho2 = TRIG_W'(pho_ff >>> Q_FRAC);

   always_ff @(posedge clock) begin
      p2_ff  <= PROD_W'(cc) * PROD_W'(ho2);
      hl2_ff <= TRIG_W'(phl_ff >>> Q_FRAC);
   end

   // sum and clamp a to [0, 1]
   assign a_sum = ASUM_W'(hl2_ff) + ASUM_W'(p2_ff >>> Q_FRAC);

   always_comb begin
      if (a_sum < 0) begin
         a_in = '0;
      end else if (a_sum > ASUM_W'(Q_ONE)) begin
         a_in = Q_ONE;
      end else begin
         a_in = a_sum[Q_FRAC:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
   end

   // roots of a and 1-a in q30
   hav_isqrt u_sqrt_a (
      .clock(clock), .radicand(SQ_W'({a_ff, {Q_FRAC{1'b0}}})), .root(root_a));
   hav_isqrt u_sqrt_ca (
      .clock(clock), .radicand(SQ_W'({Q_ONE - a_ff, {Q_FRAC{1'b0}}})), .root(root_ca));

   // half the central angle as a binary angle
   hav_vec u_vec (
      .clock(clock), .x_start(root_ca), .y_start(root_a), .angle_out(theta));

   // radius scaling: radius * theta * pi / 2^22, rounded
   assign theta_pos = (theta < 0) ? '0 : theta[BAM_W-1:0];

   always_ff @(posedge clock) begin
      p_ff <= P_W'(radius_ff) * P_W'(theta_pos);
   end

   always_ff @(posedge clock) begin
      t1_ff <= T_W'(p_ff[P_W-1:SPLIT]) * T_W'(PI_Q29);
      t2_ff <= T_W'(p_ff[SPLIT-1:0]) * T_W'(PI_Q29);
   end

   assign acc      = ACC_W'(t1_ff) + ACC_W'(t2_ff >> SPLIT) + ROUND_HALF;
   assign dist_raw = acc[ACC_W-1:OUT_SHIFT];
   assign dist_in  = (dist_raw > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(dist_raw);

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign rsp_valid        = vld_ff[TOTAL_LAT-1];
   assign rsp_arc_distance = dist_ff;

endmodule
